// ----- design/linear_resampler_dc_reject_assert.svh -----
// Assertion macros used by the checker file lrdc_checker.sv.
`ifndef LINEAR_RESAMPLER_DC_REJECT_ASSERT_SVH
`define LINEAR_RESAMPLER_DC_REJECT_ASSERT_SVH

// An antecedent implies a consequent on the next clock edge.
`define LRDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// An antecedent implies a consequent in the same clock cycle.
`define LRDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- design/lrdc_pkg.sv -----
`default_nettype none
package lrdc_pkg;
	localparam int RATE_W = 18;
	localparam int COEF_W = 24;
	localparam int SAMP_W = 16;
	localparam int ST_W   = 40;

	// Channel modes.
	localparam logic [1:0] MODE_MONO   = 2'd0;
	localparam logic [1:0] MODE_STEREO = 2'd1;
	localparam logic [1:0] MODE_DUP    = 2'd2;
	localparam logic [1:0] MODE_PICK   = 2'd3;

	// Register indexes.
	localparam logic [2:0] REG_SRC  = 3'd0;
	localparam logic [2:0] REG_TAR  = 3'd1;
	localparam logic [2:0] REG_MODE = 3'd2;
	localparam logic [2:0] REG_PICK = 3'd3;
	localparam logic [2:0] REG_COEF = 3'd4;

	// Request to the shared divider.
	typedef struct packed {
		logic        start;
		logic [51:0] num;
		logic [RATE_W-1:0] den;
	} div_req_t;

	// Status from the shared divider.
	typedef struct packed {
		logic        done;
		logic        busy;
		logic [51:0] quo;
	} div_rsp_t;

	function automatic logic signed [SAMP_W-1:0] sat16(input logic signed [55:0] v);
		if (v > 56'sd32767) return 16'sh7fff;
		if (v < -56'sd32768) return 16'sh8000;
		return v[SAMP_W-1:0];
	endfunction

	function automatic logic signed [ST_W-1:0] sat40(input logic signed [ST_W+1:0] v);
		if (v > $signed({3'b000, {(ST_W-1){1'b1}}})) return {1'b0, {(ST_W-1){1'b1}}};
		if (v < $signed({3'b111, {(ST_W-1){1'b0}}})) return {1'b1, {(ST_W-1){1'b0}}};
		return v[ST_W-1:0];
	endfunction
endpackage
`default_nettype wire

// ----- design/lrdc_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit a cycle; signed numerator, truncating.
module lrdc_div
	import lrdc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	localparam int NW = 52;

	logic [NW-1:0]     mag_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] den_q;
	logic              neg_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [RATE_W:0]   trial;
	logic [RATE_W+1:0] diff;

	assign trial = {rem_q, mag_q[NW-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};

	// Shift and subtract over the numerator bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			mag_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				neg_q  <= req.num[NW-1];
				mag_q  <= req.num[NW-1] ? (~req.num + 1'b1) : req.num;
				den_q  <= req.den;
				rem_q  <= '0;
				cnt_q  <= 6'(NW);
			end else if (busy_q) begin
				if (!diff[RATE_W+1]) begin
					rem_q <= diff[RATE_W-1:0];
					mag_q <= {mag_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= trial[RATE_W-1:0];
					mag_q <= {mag_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.busy = busy_q;
	assign rsp.quo  = neg_q ? (~mag_q + 1'b1) : mag_q;
endmodule
`default_nettype wire

// ----- design/linear_resampler_dc_reject.sv -----
// Channel   Direction  Handshake       Payload
// in        input      valid/ready     left_in, right_in
// out       output     out_valid/ready left_out, right_out, last_of_run
// cfg       input      APB write/read  source_rate..highpass_coef
// One frame yields up to MAX_UPSAMPLE results. Each channel of a result passes through a start
// state, a wait on the shared 52-step divider and the filter states S_F0 to S_F3 and S_NEXTCH
// for the two filter stages on the shared multiplier. An output state follows, after both channels in stereo.
// A resampled frame adds its accept in S_IDLE and a closing S_END state; equal rates give one
// result in the cycle after the frame is accepted. Reset clears all state and restores
// register defaults. A stalled output holds the sequencer, and ready stays low while a
// result waits.
`default_nettype none
module linear_resampler_dc_reject
	import lrdc_pkg::*;
#(
	parameter int MAX_UPSAMPLE = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	output logic             ready,
	input  wire logic signed [15:0] left_in,
	input  wire logic signed [15:0] right_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out,
	output logic             last_of_run,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int CW = $clog2(MAX_UPSAMPLE + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_DIVW, S_F0, S_F1, S_F2, S_F3, S_NEXTCH, S_OUT, S_END
	} state_t;

	state_t state_q;
	logic [RATE_W-1:0] src_q, tar_q;
	logic [1:0]  mode_q;
	logic        pick_q;
	logic [COEF_W-1:0] coef_q;
	logic signed [15:0] prev_l_q, prev_r_q, cur_a_q, cur_r_q;
	logic [RATE_W-1:0] phase_q;
	logic [RATE_W:0]   pos_q;
	logic        seen_q;
	logic signed [ST_W-1:0] hp_q [4];
	logic [CW-1:0] n_q;
	logic        ch_q;
	logic signed [15:0] vl_q, vr_q, samp_q;
	logic signed [ST_W+1:0] t_q, d_q;
	logic signed [63:0] prod_q;
	div_req_t dreq;
	div_rsp_t drsp;

	// Configuration port.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q  <= RATE_W'(48000);
			tar_q  <= RATE_W'(16000);
			mode_q <= MODE_MONO;
			pick_q <= 1'b0;
			coef_q <= COEF_W'(12583);
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_SRC:  src_q  <= pwdata[RATE_W-1:0];
				REG_TAR:  tar_q  <= pwdata[RATE_W-1:0];
				REG_MODE: mode_q <= pwdata[1:0];
				REG_PICK: pick_q <= pwdata[0];
				REG_COEF: coef_q <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_SRC:  prdata = 32'(src_q);
			REG_TAR:  prdata = 32'(tar_q);
			REG_MODE: prdata = 32'(mode_q);
			REG_PICK: prdata = 32'(pick_q);
			REG_COEF: prdata = 32'(coef_q);
			default:  prdata = '0;
		endcase
	end

	// Interpolation numerator for the channel in work.
	logic signed [15:0] pa, pb;
	logic signed [34:0] mul_a, mul_b;
	logic signed [51:0] inum;
	assign pa = ch_q ? prev_r_q : prev_l_q;
	assign pb = ch_q ? cur_r_q : cur_a_q;
	assign mul_a = pa * $signed({1'b0, tar_q - pos_q[RATE_W-1:0]});
	assign mul_b = pb * $signed({1'b0, pos_q[RATE_W-1:0]});
	assign inum = 52'(mul_a) + 52'(mul_b);

	assign dreq.start = (state_q == S_DIV);
	assign dreq.num   = inum;
	assign dreq.den   = tar_q;

	lrdc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Shared multiplier: clamped difference times coefficient.
	logic signed [ST_W+1:0] dclamp;
	logic [1:0] hb;
	assign dclamp = (d_q > (42'sd1 <<< 36)) ? (42'sd1 <<< 36) :
		(d_q < -(42'sd1 <<< 36)) ? -(42'sd1 <<< 36) : d_q;
	assign hb = {ch_q, 1'b0};
	logic signed [ST_W+1:0] step;
	assign step = 42'(((prod_q + 64'sd8388608) >>> 24));

	logic signed [ST_W+1:0] xin;
	assign xin = 42'(samp_q) <<< 16;
	logic signed [ST_W+1:0] ydiv;
	assign ydiv = (t_q - 42'(hp_q[hb + 2'd1])) / 42'sd65536;

	logic signed [15:0] a_in;
	assign a_in = (mode_q == MODE_PICK && pick_q) ? right_in : left_in;
	assign ready = (state_q == S_IDLE) && !out_valid;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid   <= 1'b0;
			seen_q      <= 1'b0;
			phase_q     <= '0;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			cur_a_q     <= '0;
			cur_r_q     <= '0;
			pos_q       <= '0;
			n_q         <= '0;
			ch_q        <= 1'b0;
			vl_q        <= '0;
			vr_q        <= '0;
			samp_q      <= '0;
			t_q         <= '0;
			d_q         <= '0;
			prod_q      <= '0;
			left_out    <= '0;
			right_out   <= '0;
			last_of_run <= 1'b0;
			for (int i = 0; i < 4; i++) hp_q[i] <= '0;
		end else begin
			if (out_valid && out_ready && state_q != S_OUT) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (valid && ready) begin
					cur_a_q <= a_in;
					cur_r_q <= right_in;
					if (src_q == tar_q) begin
						left_out    <= a_in;
						right_out   <= (mode_q == MODE_STEREO) ? right_in :
							(mode_q == MODE_DUP) ? a_in : 16'sd0;
						last_of_run <= 1'b1;
						out_valid   <= 1'b1;
					end else if (!seen_q || tar_q == '0
							|| {1'b0, phase_q} >= {1'b0, tar_q}) begin
						prev_l_q <= a_in;
						prev_r_q <= right_in;
						seen_q   <= 1'b1;
						if (seen_q) phase_q <= (phase_q >= tar_q && tar_q != '0) ?
							phase_q - tar_q : ((tar_q == '0) ? phase_q : '0);
					end else begin
						pos_q   <= {1'b0, phase_q};
						n_q     <= '0;
						ch_q    <= 1'b0;
						state_q <= S_DIV;
					end
				end
				S_DIV: state_q <= S_DIVW;
				S_DIVW: if (drsp.done) begin
					samp_q  <= sat16(56'($signed(drsp.quo)));
					state_q <= S_F0;
				end
				S_F0: begin
					t_q     <= xin - 42'(hp_q[hb]);
					d_q     <= xin - 42'(hp_q[hb]);
					state_q <= S_F1;
				end
				S_F1: begin
					prod_q  <= 64'(dclamp) * $signed({1'b0, coef_q});
					state_q <= S_F2;
				end
				S_F2: begin
					hp_q[hb] <= sat40(42'(hp_q[hb]) + step);
					d_q      <= t_q - 42'(hp_q[hb + 2'd1]);
					state_q  <= S_F3;
				end
				S_F3: begin
					prod_q  <= 64'(dclamp) * $signed({1'b0, coef_q});
					if (ch_q) vr_q <= sat16(56'(ydiv));
					else      vl_q <= sat16(56'(ydiv));
					state_q <= S_NEXTCH;
				end
				S_NEXTCH: begin
					hp_q[hb + 2'd1] <= sat40(42'(hp_q[hb + 2'd1]) + step);
					if (!ch_q && mode_q == MODE_STEREO) begin
						ch_q    <= 1'b1;
						state_q <= S_DIV;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: if (!out_valid || out_ready) begin
					logic [RATE_W:0] np;
					logic [CW-1:0]   nn;
					np = pos_q + {1'b0, src_q};
					nn = n_q + 1'b1;
					left_out    <= vl_q;
					right_out   <= (mode_q == MODE_STEREO) ? vr_q :
						(mode_q == MODE_DUP) ? vl_q : 16'sd0;
					out_valid   <= 1'b1;
					pos_q       <= np;
					n_q         <= nn;
					ch_q        <= 1'b0;
					last_of_run <= !(np < {1'b0, tar_q} && nn < CW'(MAX_UPSAMPLE));
					if (np < {1'b0, tar_q} && nn < CW'(MAX_UPSAMPLE)) state_q <= S_DIV;
					else state_q <= S_END;
				end
				S_END: begin
					phase_q  <= (pos_q < {1'b0, tar_q}) ? '0 :
						RATE_W'(pos_q - {1'b0, tar_q});
					prev_l_q <= cur_a_q;
					prev_r_q <= cur_r_q;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/lrdc_checker.sv -----
`default_nettype none
`include "linear_resampler_dc_reject_assert.svh"
// Port-level checks on the resampler.
module lrdc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        valid,
	input wire logic        ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] left_out,
	input wire logic [15:0] right_out,
	input wire logic        last_of_run,
	input wire logic        pready
);
	// Whole output beat, so its hold can be checked as one value.
	logic [32:0] out_beat;
	assign out_beat = {left_out, right_out, last_of_run};

	`LRDC_ASSERT_SAME(a_pready, clk, arst_n, 1'b1, pready, "pready low")
	`LRDC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid,
		"result dropped")
	`LRDC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_beat),
		"result changed while waiting")
	`LRDC_ASSERT_SAME(a_accept_free, clk, arst_n, valid && ready, !out_valid,
		"frame accepted while a result waits")
endmodule

bind linear_resampler_dc_reject lrdc_checker u_chk (.*);
`default_nettype wire
